[hw/rtl/ttip_pkg.sv]
package ttip_pkg;

  localparam int unsigned BASE_W      = 6;
  localparam int unsigned DIGIT_W     = 7;
  localparam int unsigned END_POS_W   = 12;
  localparam int unsigned MAX_POS_DEF = 4095;

  localparam logic [BASE_W-1:0]  BASE_RESET = 6'd10;
  localparam logic [BASE_W-1:0]  BASE_DEC   = 6'd10;
  localparam logic [BASE_W-1:0]  BASE_OCT   = 6'd8;
  localparam logic [BASE_W-1:0]  BASE_HEX   = 6'd16;
  localparam logic [BASE_W-1:0]  BASE_MAX   = 6'd36;
  localparam logic [DIGIT_W-1:0] NO_DIGIT   = 7'd99;

  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_X     = 8'd120;
  localparam logic [7:0] CH_SPACE = 8'd32;

  localparam logic [63:0] POS_LIMIT = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] NEG_LIMIT = 64'h8000_0000_0000_0000;

  typedef enum logic [5:0] {
    PH_IDLE   = 6'b000001,
    PH_SPACE  = 6'b000010,
    PH_PREFIX = 6'b000100,
    PH_ZERO   = 6'b001000,
    PH_DIGITS = 6'b010000,
    PH_DONE   = 6'b100000
  } phase_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       first;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0]    value;
    logic                  saturated;
    logic [END_POS_W-1:0]  end_pos;
  } out_item_t;

  typedef struct packed {
    phase_e             phase;
    logic [63:0]        magnitude;
    logic               negative;
    logic [BASE_W-1:0]  active_base;
    logic               overflowed;
  } parse_state_t;

  typedef struct packed {
    logic consume;
    logic done;
  } step_ctrl_t;

  function automatic logic [DIGIT_W-1:0] digit_of(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd0;
    if (c inside {[8'd48:8'd57]}) begin
      d = c - 8'd48;
    end else if (c inside {[8'd97:8'd122]}) begin
      d = c - 8'd87;
    end else if (c inside {[8'd65:8'd90]}) begin
      d = c - 8'd55;
    end else begin
      d = {1'b0, NO_DIGIT};
    end
    return d[DIGIT_W-1:0];
  endfunction

endpackage

[hw/rtl/ttip_step.sv]
module ttip_step
  import ttip_pkg::*;
(
  input  parse_state_t       state_i,
  input  in_item_t           item_i,
  input  logic [BASE_W-1:0]  base_sel_i,
  output parse_state_t       state_o,
  output step_ctrl_t         ctrl_o,
  output logic signed [63:0] value_o,
  output logic               saturated_o
);

  parse_state_t       st;
  logic               stop;
  logic [7:0]         c;
  logic [DIGIT_W-1:0] d;
  logic [69:0]        acc;
  logic [69:0]        limit;

  assign c = item_i.ch;
  assign d = digit_of(c);

  always_comb begin
    st             = state_i;
    stop           = 1'b0;
    ctrl_o.consume = 1'b0;
    ctrl_o.done    = 1'b0;
    acc            = 70'd0;
    limit          = 70'd0;

    // restart: drop any string in progress
    if (item_i.first) begin
      st.phase       = PH_SPACE;
      st.magnitude   = 64'd0;
      st.negative    = 1'b0;
      st.overflowed  = 1'b0;
      st.active_base = (base_sel_i > BASE_MAX) ? BASE_MAX : base_sel_i;
    end

    if (st.phase != PH_IDLE && st.phase != PH_DONE) begin
      if (st.phase == PH_SPACE) begin
        if (c inside {CH_SPACE, [8'd9:8'd13]}) begin
          ctrl_o.consume = 1'b1;
          stop           = 1'b1;
        end else begin
          st.phase = PH_PREFIX;
          if (c == CH_MINUS) begin
            st.negative    = 1'b1;
            ctrl_o.consume = 1'b1;
            stop           = 1'b1;
          end
        end
      end

      if (!stop && st.phase == PH_PREFIX) begin
        if (st.active_base == '0) begin
          if (c == CH_ZERO) begin
            ctrl_o.consume = 1'b1;
            st.phase       = PH_ZERO;
            stop           = 1'b1;
          end else begin
            st.active_base = BASE_DEC;
          end
        end
        if (!stop) begin
          st.phase = PH_DIGITS;
        end
      end else if (!stop && st.phase == PH_ZERO) begin
        st.phase = PH_DIGITS;
        if (c == CH_X) begin
          st.active_base = BASE_HEX;
          ctrl_o.consume = 1'b1;
          stop           = 1'b1;
        end else begin
          st.active_base = BASE_OCT;
        end
      end

      if (!stop && st.phase == PH_DIGITS) begin
        if (st.active_base == '0 || d >= DIGIT_W'(st.active_base)) begin
          ctrl_o.done = 1'b1;
        end else begin
          // exact test: mag * base + digit must not pass the signed limit
          acc   = 70'(st.magnitude) * 70'(st.active_base) + 70'(d);
          limit = st.negative ? 70'(NEG_LIMIT) : 70'(POS_LIMIT);
          if (!st.overflowed) begin
            if (acc > limit) begin
              st.overflowed = 1'b1;
            end else begin
              st.magnitude = acc[63:0];
            end
          end
          ctrl_o.consume = 1'b1;
        end
      end

      // last acts as if a terminator follows
      if (item_i.last) begin
        ctrl_o.done = 1'b1;
      end
      if (ctrl_o.done) begin
        st.phase = PH_DONE;
      end
    end
  end

  assign state_o     = st;
  assign saturated_o = st.overflowed;

  always_comb begin
    if (st.overflowed) begin
      value_o = st.negative ? NEG_LIMIT : POS_LIMIT;
    end else begin
      value_o = st.negative ? (64'd0 - st.magnitude) : st.magnitude;
    end
  end

endmodule

[hw/rtl/text_to_integer_parser.sv]
// Streaming text to integer converter, one item per cycle when not stalled.
// Input channel: in_valid_i / in_stall_o carry in_item_t (ch, first, last).
//   Set first on the opening character of a string; set last on its final
//   character to end the string as if a terminator followed.
// Output channel: out_valid_o / out_stall_i carry out_item_t with the signed
//   value, the saturation flag and the end offset. Each string gives at most
//   one result item, no later than its last character.
// Configuration: cfg_we_i writes cfg_wdata_i into the base register
//   (0 detects the base from the prefix). The base is taken when a string
//   starts; write it only while the block is idle.
// Path: the ending item passes the input register, then the parse step
//   into the result register.
// Throughput: 1 item per cycle while no result stalls. The critical path is
//   the 64 by 6 bit multiply-add and limit compare of the digit accumulator.
// Reset: clears the parser to idle, empties both registers, base to 10.
// Stall: a stalled result holds in the output register; the input register
//   then holds its item and in_stall_o rises until the result is taken.
module text_to_integer_parser
  import ttip_pkg::*;
#(
  parameter int unsigned MAX_POS = MAX_POS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [BASE_W-1:0] cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_item_t          in_item_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_item_t         out_item_o
);

  localparam int unsigned POS_W = $clog2(MAX_POS + 1);

  // base register
  logic [BASE_W-1:0] base_q;

  // input register
  logic     s1_valid_q, s1_valid_d;
  in_item_t s1_item_q;
  logic     s1_fire;
  logic     in_accept;

  // parser state
  parse_state_t     state_q, state_d;
  logic [POS_W-1:0] pos_q, pos_d;

  // step outputs
  step_ctrl_t         ctrl;
  logic signed [63:0] step_value;
  logic               step_sat;

  // result register
  logic      out_valid_q, out_valid_d;
  out_item_t out_item_q;

  logic [POS_W+END_POS_W-1:0] pos_ext;

  // advance the input item whenever the result slot is free or drains now
  assign s1_fire    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_fire;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_fire) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= BASE_RESET;
    end else if (cfg_we_i) begin
      base_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  // payload: hold while stalled
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_item_q <= in_item_i;
    end
  end

  ttip_step u_step (
    .state_i     (state_q),
    .item_i      (s1_item_q),
    .base_sel_i  (base_q),
    .state_o     (state_d),
    .ctrl_o      (ctrl),
    .value_o     (step_value),
    .saturated_o (step_sat)
  );

  // character count: restart on first, saturate at MAX_POS
  always_comb begin
    pos_d = s1_item_q.first ? '0 : pos_q;
    if (ctrl.consume && pos_d < POS_W'(MAX_POS)) begin
      pos_d = pos_d + POS_W'(1);
    end
  end

  assign pos_ext = {{END_POS_W{1'b0}}, pos_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{phase: PH_IDLE, magnitude: 64'd0, negative: 1'b0,
                   active_base: '0, overflowed: 1'b0};
      pos_q   <= '0;
    end else if (s1_fire) begin
      state_q <= state_d;
      pos_q   <= pos_d;
    end
  end

  // result slot: load on a finished string, drop once taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_fire && ctrl.done) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && ctrl.done) begin
      out_item_q.value     <= step_value;
      out_item_q.saturated <= step_sat;
      out_item_q.end_pos   <= pos_ext[END_POS_W-1:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // a clamped result is always one of the two limits
  a_sat_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_item_q.saturated |->
      (out_item_q.value == POS_LIMIT) || (out_item_q.value == NEG_LIMIT))
    else $error("saturated result is not a limit value");

  // a new result appears only after a parse step
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !$past(out_valid_q) |-> $past(s1_fire))
    else $error("result appeared without a parse step");

  // an active string ends on its last character
  a_last_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && s1_item_q.last &&
      (s1_item_q.first || (state_q.phase != PH_IDLE && state_q.phase != PH_DONE))
      |=> out_valid_q)
    else $error("last character gave no result");

  // character count stays within its saturation point
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= POS_W'(MAX_POS))
    else $error("position beyond MAX_POS");

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb
  import ttip_pkg::*;
();

  // Run limits, in clock cycles.
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned IDLE_SETTLE  = 4;   // input register plus parse step, with margin
  localparam int unsigned DRAIN_CYCLES = 8;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic [BASE_W-1:0] cfg_wdata = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  in_item_t          in_item = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_item_t         out_item;

  // Percent of cycles in which each side holds off.
  int unsigned gap_pct   = 29;
  int unsigned stall_pct = 29;

  int unsigned error_count  = 0;
  int unsigned items_parsed = 0;
  int unsigned cycle_count  = 0;

  // Parser image: base register copy and the per-string state.
  logic [BASE_W-1:0] base_reg = BASE_RESET;
  phase_e            prs_phase = PH_IDLE;
  logic [63:0]       prs_mag = '0;
  logic              prs_neg = 1'b0;
  logic [BASE_W-1:0] prs_base = '0;
  logic [11:0]       prs_pos = '0;
  logic              prs_ovf = 1'b0;

  // Results predicted but not yet seen on the output, oldest first.
  out_item_t pending_results[$];

  text_to_integer_parser dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------

  function automatic int unsigned char_value(input logic [7:0] c);
    if (c >= "0" && c <= "9") return 32'(c - "0");
    if (c >= "a" && c <= "z") return 32'(c - "a") + 10;
    if (c >= "A" && c <= "Z") return 32'(c - "A") + 10;
    return 32'(NO_DIGIT);
  endfunction

  function automatic bit is_blank(input logic [7:0] c);
    return c == CH_SPACE || (c >= 8'd9 && c <= 8'd13);
  endfunction

  // Count one consumed character; the offset sticks at its maximum.
  function automatic void advance_pos();
    if (prs_pos < MAX_POS_DEF) prs_pos++;
  endfunction

  // Clamp on overflow, else apply the sign to the magnitude.
  function automatic void close_string();
    out_item_t r;
    if (prs_ovf) begin
      r.value = prs_neg ? NEG_LIMIT : POS_LIMIT;
    end else begin
      r.value = prs_neg ? -prs_mag : prs_mag;
    end
    r.saturated = prs_ovf;
    r.end_pos   = prs_pos;
    pending_results.push_back(r);
    prs_phase = PH_DONE;
  endfunction

  // Feed one character to the parser image; return 1 once the string ends.
  function automatic bit parse_char(input logic [7:0] c);
    int unsigned d;
    logic [63:0] lim;
    if (prs_phase == PH_SPACE) begin
      if (is_blank(c)) begin
        advance_pos();
        return 1'b0;
      end
      prs_phase = PH_PREFIX;
      if (c == CH_MINUS) begin
        prs_neg = 1'b1;
        advance_pos();
        return 1'b0;
      end
    end
    if (prs_phase == PH_PREFIX) begin
      if (prs_base == '0) begin
        if (c == CH_ZERO) begin
          advance_pos();
          prs_phase = PH_ZERO;
          return 1'b0;
        end
        prs_base = BASE_DEC;
      end
      prs_phase = PH_DIGITS;
    end else if (prs_phase == PH_ZERO) begin
      // A leading zero picks octal unless a lowercase x follows.
      prs_phase = PH_DIGITS;
      if (c == CH_X) begin
        prs_base = BASE_HEX;
        advance_pos();
        return 1'b0;
      end
      prs_base = BASE_OCT;
    end
    if (prs_phase == PH_DIGITS) begin
      d = char_value(c);
      if (prs_base == '0 || d >= prs_base) begin
        close_string();
        return 1'b1;
      end
      // Exact magnitude check: a minus sign allows one more than the maximum.
      if (!prs_ovf) begin
        lim = prs_neg ? NEG_LIMIT : POS_LIMIT;
        if (prs_mag > (lim - d) / prs_base) begin
          prs_ovf = 1'b1;
        end else begin
          prs_mag = prs_mag * prs_base + d;
        end
      end
      advance_pos();
    end
    return 1'b0;
  endfunction

  // Apply one accepted item; return 1 if the parser was working on a string.
  function automatic bit parse_step(input in_item_t it);
    bit done;
    if (it.first) begin
      prs_phase = PH_SPACE;
      prs_mag   = '0;
      prs_neg   = 1'b0;
      prs_pos   = '0;
      prs_ovf   = 1'b0;
      prs_base  = (base_reg > BASE_MAX) ? BASE_MAX : base_reg;
    end
    if (prs_phase == PH_IDLE || prs_phase == PH_DONE) return 1'b0;
    done = parse_char(it.ch);
    // A last marker behaves as if a terminator byte followed.
    if (!done && it.last) done = parse_char(8'd0);
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_count, what, got, want);
    error_count++;
  endtask

  task automatic compare_result(input out_item_t got);
    out_item_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("unexpected result, value", got.value, '0);
      return;
    end
    want = pending_results.pop_front();
    if (got.value !== want.value) report_mismatch("value", got.value, want.value);
    if (got.saturated !== want.saturated) begin
      report_mismatch("saturated", 64'(got.saturated), 64'(want.saturated));
    end
    if (got.end_pos !== want.end_pos) begin
      report_mismatch("end_pos", 64'(got.end_pos), 64'(want.end_pos));
    end
  endtask

  // Take each result on the handshake, then pick the stall for the next cycle.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) compare_result(out_item);
    out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  // Stop a hung run.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[text_to_integer_parser] ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------

  // Drive one item and hold it until accepted. Valid stays high afterwards,
  // so back-to-back items keep the channel full; a gap lowers it first.
  task automatic send_item(input logic [7:0] c, input logic is_first, input logic is_last);
    in_item_t it;
    it.ch    = c;
    it.first = is_first;
    it.last  = is_last;
    while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (parse_step(it)) items_parsed++;
  endtask

  // Send a text as one string; mark the final character last if asked.
  task automatic send_text(input string s, input bit mark_last);
    int i;
    for (i = 0; i < s.len(); i++) begin
      send_item(s[i], i == 0, mark_last && i == s.len() - 1);
    end
  endtask

  // Drain the output, let the pipeline settle, then load the base register.
  task automatic write_base(input logic [BASE_W-1:0] b);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (IDLE_SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= b;
    @(posedge clk);
    cfg_we   <= 1'b0;
    base_reg = b;
  endtask

  function automatic logic [7:0] blank_char();
    int unsigned n;
    n = $urandom_range(0, 5);
    return (n == 5) ? CH_SPACE : 8'(9 + n);
  endfunction

  // Digit in either letter case.
  function automatic logic [7:0] digit_char(input int unsigned d);
    logic [7:0] letter;
    if (d < 10) return CH_ZERO + 8'(d);
    letter = $urandom_range(1) ? "a" : "A";
    return letter + 8'(d - 10);
  endfunction

  // Mostly well-formed strings: blanks, sign, prefix, digits near the
  // interesting magnitudes, then an ending of one of several kinds.
  task automatic send_random_string();
    logic [7:0]  chars[$];
    logic [7:0]  digits[$];
    logic [63:0] mag;
    int unsigned radix;
    int unsigned ending;
    int          i;
    bit          mark_last;
    // Noise: raw bytes with random markers.
    if ($urandom_range(99) < 12) begin
      repeat ($urandom_range(1, 6)) begin
        send_item(8'($urandom_range(255)), 1'($urandom_range(1)), 1'($urandom_range(1)));
      end
      return;
    end
    repeat ($urandom_range(0, 2)) chars.push_back(blank_char());
    if ($urandom_range(1)) chars.push_back(CH_MINUS);
    radix = (base_reg > BASE_MAX) ? BASE_MAX : base_reg;
    if (radix == 0) begin
      case ($urandom_range(2))
        0: begin
          chars.push_back(CH_ZERO);
          chars.push_back(CH_X);
          radix = BASE_HEX;
        end
        1: begin
          chars.push_back(CH_ZERO);
          radix = BASE_OCT;
        end
        default: radix = BASE_DEC;
      endcase
    end
    if (radix == 1) begin
      // Only the digit zero counts in base one.
      repeat ($urandom_range(1, 4)) chars.push_back(CH_ZERO);
    end else begin
      case ($urandom_range(3))
        0: mag = 64'($urandom_range(0, 1000));
        1: mag = {$urandom, $urandom} >> $urandom_range(0, 63);
        2: mag = NEG_LIMIT - 64'd2 + 64'($urandom_range(0, 4));
        default: mag = {$urandom, $urandom};
      endcase
      do begin
        digits.push_front(digit_char(32'(mag % radix)));
        mag = mag / radix;
      end while (mag != 0);
      if ($urandom_range(3) == 0) digits.push_front(CH_ZERO);
      // Push past the range with extra digits now and then.
      if ($urandom_range(3) == 0) begin
        repeat ($urandom_range(1, 4)) digits.push_back(digit_char($urandom_range(0, radix - 1)));
      end
      chars = {chars, digits};
    end
    ending    = $urandom_range(3);
    mark_last = (ending == 0 || ending == 1);
    if (ending == 1 || ending == 2) begin
      case ($urandom_range(2))
        0: chars.push_back(8'd0);
        1: chars.push_back(8'($urandom_range(128, 255)));
        default: chars.push_back(8'($urandom_range(255)));
      endcase
    end
    for (i = 0; i < chars.size(); i++) begin
      send_item(chars[i], i == 0, mark_last && i == chars.size() - 1);
    end
    // Stray characters after the end of the string.
    if (ending == 2) begin
      repeat ($urandom_range(0, 2)) begin
        send_item(8'($urandom_range(255)), 1'b0, 1'($urandom_range(1)));
      end
    end
  endtask

  task automatic run_random_phase(input logic [BASE_W-1:0] b, input int unsigned n_items);
    int unsigned stop_at;
    write_base(b);
    stop_at = items_parsed + n_items;
    while (items_parsed < stop_at) send_random_string();
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  task automatic test_directed();
    // Decimal after reset.
    send_item("q", 1'b0, 1'b1);          // stray while idle: dropped
    send_text(" \t-42", 1'b1);           // blanks and a minus sign
    send_text("-", 1'b1);                // sign without digits
    send_text("7", 1'b0);
    send_item(8'hff, 1'b0, 1'b0);        // high byte ends the digits
    send_text("3", 1'b0);
    send_text("5", 1'b1);                // restart drops the open string
    send_text("1", 1'b0);
    send_item(8'h00, 1'b0, 1'b0);        // zero byte ends the digits
    send_text("9z8", 1'b1);              // characters after the end are dropped
    // Prefix detection.
    write_base('0);
    send_text("0x1F", 1'b1);
    send_text("0x", 1'b1);               // hex prefix with no digit
    send_text("017", 1'b1);
  endtask

  task automatic test_random_bases();
    logic [BASE_W-1:0] plan [10] = '{6'd2, BASE_HEX, 6'd0, BASE_MAX, 6'd1, 6'd37,
                                      6'd63, BASE_OCT, 6'd7, BASE_DEC};
    int i;
    for (i = 0; i < 10; i++) run_random_phase(plan[i], 40);
  endtask

  // Full rate on both sides.
  task automatic test_full_rate();
    gap_pct   = 0;
    stall_pct = 0;
    run_random_phase('0, 90);
    gap_pct   = 29;
    stall_pct = 29;
  endtask

  // A long run of blanks and leading zeros before the final digit.
  task automatic test_long_string();
    int i;
    write_base(BASE_DEC);
    send_item(CH_SPACE, 1'b1, 1'b0);
    for (i = 0; i < 20; i++) send_item(blank_char(), 1'b0, 1'b0);
    send_item(CH_MINUS, 1'b0, 1'b0);
    for (i = 0; i < 40; i++) send_item(CH_ZERO, 1'b0, 1'b0);
    send_item("7", 1'b0, 1'b1);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_bases();
    test_full_rate();
    test_long_string();
    // Wait out every pending result, then hold a few cycles for strays.
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("[text_to_integer_parser] OK");
    end else begin
      $display("[text_to_integer_parser] ERROR");
    end
    $finish;
  end

endmodule
